### sv/jpdpi_pkg.sv
package jpdpi_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHOULDER_KP = 3'd0,
    REG_SHOULDER_KD = 3'd1,
    REG_ELBOW_KP    = 3'd2,
    REG_ELBOW_KD    = 3'd3,
    REG_WHEEL_KP    = 3'd4,
    REG_WHEEL_KI    = 3'd5,
    REG_WHEEL_TGT   = 3'd6,
    REG_JUMP_LIMIT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CH_SHOULDER_POS = 3'd0,
    CH_ELBOW_POS    = 3'd1,
    CH_SHOULDER_VEL = 3'd2,
    CH_ELBOW_VEL    = 3'd3,
    CH_WHEEL_POS    = 3'd4
  } channel_t;

  localparam logic [31:0] VelJumpLimit = 32'd19661;
  localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;

  // Sequencer steps: one step per multiply, DivSteps divider steps in ST_DIV_RUN.
  // The integral term is multiplied in two halves (upper, lower 24 bits).
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SH_P,
    ST_SH_D,
    ST_EL_P,
    ST_EL_D,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_RATE,
    ST_INTEG,
    ST_WH_P,
    ST_WH_I,
    ST_WH_I_LO,
    ST_DONE,
    ST_OUT
  } state_t;

  localparam int unsigned DivSteps = 57;
  localparam int unsigned DivCntW = 6;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic take_sample;
    logic clr_acc;
    logic mac_sh_p;
    logic mac_sh_d;
    logic fin_sh;
    logic mac_el_p;
    logic mac_el_d;
    logic fin_el;
    logic div_start;
    logic div_step;
    logic rate_done;
    logic integ;
    logic mac_wh_p;
    logic mac_wh_i;
    logic mac_wh_i_lo;
    logic finish;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

### sv/jpdpi_ctrl.sv
module jpdpi_ctrl
  import jpdpi_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_fire,
  input  logic   in_action,
  input  logic   out_free,
  output logic   busy,
  output logic   out_load,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    out_load  = 1'b0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = in_action ? ST_SH_P : ST_SAMPLE;
        cmd.clr_acc = 1'b1;
      end
      ST_SAMPLE: begin
        cmd.take_sample = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SH_P: begin cmd.mac_sh_p = 1'b1; state_nxt = ST_SH_D; end
      ST_SH_D: begin cmd.mac_sh_d = 1'b1; state_nxt = ST_EL_P; end
      ST_EL_P: begin cmd.fin_sh = 1'b1; cmd.mac_el_p = 1'b1; state_nxt = ST_EL_D; end
      ST_EL_D: begin cmd.mac_el_d = 1'b1; state_nxt = ST_DIV_START; end
      ST_DIV_START: begin
        cmd.fin_el = 1'b1;
        cmd.div_start = 1'b1;
        cnt_nxt = '0;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivSteps - 1)) state_nxt = ST_RATE;
      end
      ST_RATE: begin cmd.rate_done = 1'b1; state_nxt = ST_INTEG; end
      ST_INTEG: begin cmd.integ = 1'b1; state_nxt = ST_WH_P; end
      ST_WH_P: begin cmd.mac_wh_p = 1'b1; state_nxt = ST_WH_I; end
      ST_WH_I: begin cmd.mac_wh_i = 1'b1; state_nxt = ST_WH_I_LO; end
      ST_WH_I_LO: begin cmd.mac_wh_i_lo = 1'b1; state_nxt = ST_DONE; end
      ST_DONE: begin cmd.finish = 1'b1; state_nxt = ST_OUT; end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### sv/jpdpi_dp.sv
module jpdpi_dp
  import jpdpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic               in_fire,
  input  logic [2:0]         in_channel,
  input  logic signed [31:0] in_sample_value,
  input  logic [23:0]        in_step_seconds,
  input  logic signed [31:0] in_sh_tp,
  input  logic signed [31:0] in_sh_tv,
  input  logic signed [31:0] in_el_tp,
  input  logic signed [31:0] in_el_tv,
  input  logic               cfg_fire,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] res_sh,
  output logic signed [31:0] res_el,
  output logic signed [31:0] res_wh,
  output logic signed [31:0] res_rate
);

  // Configuration registers
  logic [31:0] sh_kp_r, sh_kd_r, el_kp_r, el_kd_r, wh_kp_r, wh_ki_r;
  logic signed [31:0] wh_tgt_r;
  logic [30:0] jump_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_kp_r  <= 32'd414217169;
      sh_kd_r  <= 32'd41421717;
      el_kp_r  <= 32'd48426873;
      el_kd_r  <= 32'd4842687;
      wh_kp_r  <= 32'd33414846;
      wh_ki_r  <= 32'd3350074;
      wh_tgt_r <= 32'sd9830400;
      jump_r   <= 31'd3277;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHOULDER_KP: sh_kp_r  <= cfg_data;
        REG_SHOULDER_KD: sh_kd_r  <= cfg_data;
        REG_ELBOW_KP:    el_kp_r  <= cfg_data;
        REG_ELBOW_KD:    el_kd_r  <= cfg_data;
        REG_WHEEL_KP:    wh_kp_r  <= cfg_data;
        REG_WHEEL_KI:    wh_ki_r  <= cfg_data;
        REG_WHEEL_TGT:   wh_tgt_r <= cfg_data;
        REG_JUMP_LIMIT:  jump_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Item capture
  logic [2:0]         ch_r;
  logic signed [31:0] val_r, stp_r, stv_r, etp_r, etv_r;
  logic [23:0]        dt_r;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r <= in_channel; val_r <= in_sample_value; dt_r <= in_step_seconds;
      stp_r <= in_sh_tp; stv_r <= in_sh_tv; etp_r <= in_el_tp; etv_r <= in_el_tv;
    end
  end

  // Sensor state
  logic signed [31:0] sp_r, ep_r, sv_r, ev_r, wp_r, wpl_r, stl_r, etl_r;
  logic sseen_r, eseen_r;
  logic signed [47:0] sum_r;

  logic signed [32:0] d_sp, d_ep, d_sv, d_ev;
  logic [32:0] a_sp, a_ep, a_sv, a_ev;
  assign d_sp = 33'(val_r) - 33'(sp_r);
  assign d_ep = 33'(val_r) - 33'(ep_r);
  assign d_sv = 33'(val_r) - 33'(sv_r);
  assign d_ev = 33'(val_r) - 33'(ev_r);
  assign a_sp = d_sp[32] ? 33'(-d_sp) : 33'(d_sp);
  assign a_ep = d_ep[32] ? 33'(-d_ep) : 33'(d_ep);
  assign a_sv = d_sv[32] ? 33'(-d_sv) : 33'(d_sv);
  assign a_ev = d_ev[32] ? 33'(-d_ev) : 33'(d_ev);

  // Wheel speed error: current rate against the target
  logic signed [32:0] werr_r, werr_c;
  assign werr_c = 33'(wh_tgt_r) - 33'(rate_r);

  // Shared multiplier: 33-bit signed operand by 32-bit unsigned gain.
  // The 48-bit integral goes through in two halves: upper 24 bits signed,
  // lower 24 bits unsigned.
  logic signed [32:0] m_a;
  logic [31:0]        m_g;
  logic signed [65:0] m_p;
  logic signed [81:0] m_term;
  logic signed [81:0] acc_r;
  logic signed [63:0] tq_sh_r, tq_el_r;

  always_comb begin
    m_a = '0;
    m_g = '0;
    if (cmd.mac_sh_p) begin m_a = 33'(stp_r) - 33'(sp_r); m_g = sh_kp_r; end
    else if (cmd.mac_sh_d) begin m_a = 33'(stv_r) - 33'(sv_r); m_g = sh_kd_r; end
    else if (cmd.mac_el_p) begin m_a = 33'(etp_r) - 33'(ep_r); m_g = el_kp_r; end
    else if (cmd.mac_el_d) begin m_a = 33'(etv_r) - 33'(ev_r); m_g = el_kd_r; end
    else if (cmd.mac_wh_p) begin m_a = werr_r; m_g = wh_kp_r; end
    else if (cmd.mac_wh_i) begin m_a = 33'($signed(sum_r[47:24])); m_g = wh_ki_r; end
    else if (cmd.mac_wh_i_lo) begin m_a = {9'd0, sum_r[23:0]}; m_g = wh_ki_r; end
  end
  assign m_p = 66'(m_a) * $signed({34'd0, m_g});
  // Each gain term is floored to Q4.28 on its own; the upper integral half
  // carries weight 2^24, so it scales up exactly.
  assign m_term = cmd.mac_wh_i ? (82'(m_p) <<< 4) : 82'(m_p >>> 20);

  // Divider: restoring, |diff|*2^24 by dt, quotient magnitude
  logic [56:0] dq_r;
  logic [24:0] drem_r;
  logic        dneg_r;
  logic signed [32:0] diff;
  logic [32:0]        adiff;
  logic [24:0]        trial;
  logic signed [31:0] rate_r;
  assign diff  = 33'(wp_r) - 33'(wpl_r);
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
  assign trial = {drem_r[23:0], dq_r[56]} - {1'b0, dt_r};

  logic signed [57:0] qs;
  assign qs = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
  logic signed [56:0] ip;
  logic signed [48:0] sum_n;
  assign ip = 57'(werr_c) * $signed({33'd0, dt_r});
  assign sum_n = 49'(sum_r) + 49'(ip >>> 24);

  logic signed [63:0] acc_q;
  assign acc_q = 64'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0; ep_r <= '0; sv_r <= '0; ev_r <= '0; wp_r <= '0; wpl_r <= '0;
      stl_r <= '0; etl_r <= '0; sseen_r <= 1'b0; eseen_r <= 1'b0; sum_r <= '0;
    end else begin
      if (cmd.take_sample) begin
        case (ch_r)
          CH_SHOULDER_POS: if (!sseen_r || a_sp <= {2'b0, jump_r}) begin
            sp_r <= val_r; sseen_r <= 1'b1; end
          CH_ELBOW_POS: if (!eseen_r || a_ep <= {2'b0, jump_r}) begin
            ep_r <= val_r; eseen_r <= 1'b1; end
          CH_SHOULDER_VEL: if (a_sv <= {1'b0, VelJumpLimit}) sv_r <= val_r;
          CH_ELBOW_VEL: if (a_ev <= {1'b0, VelJumpLimit}) ev_r <= val_r;
          CH_WHEEL_POS: wp_r <= val_r;
          default: ;
        endcase
      end
      if (cmd.rate_done) wpl_r <= wp_r;
      if (cmd.integ) begin
        if (sum_n > 49'(SumMax)) sum_r <= SumMax;
        else if (sum_n < 49'(SumMin)) sum_r <= SumMin;
        else sum_r <= sum_n[47:0];
      end
      if (cmd.finish) begin
        stl_r <= 32'(sat32(-tq_sh_r));
        etl_r <= 32'(sat32(tq_el_r));
      end
    end
  end

  // Datapath work registers
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) acc_r <= '0;
    else if (cmd.fin_sh || cmd.mac_wh_p) acc_r <= m_term;
    else if (cmd.mac_sh_p || cmd.mac_sh_d || cmd.mac_el_d || cmd.mac_wh_i ||
             cmd.mac_wh_i_lo)
      acc_r <= acc_r + m_term;
    if (cmd.fin_sh) tq_sh_r <= acc_q;
    if (cmd.fin_el) tq_el_r <= acc_q;
    if (cmd.div_start) begin
      dq_r <= {adiff[32:0], 24'd0};
      drem_r <= '0;
      dneg_r <= diff[32];
    end
    if (cmd.div_step) begin
      if (!trial[24]) begin
        drem_r <= trial; dq_r <= {dq_r[55:0], 1'b1};
      end else begin
        drem_r <= {drem_r[23:0], dq_r[56]}; dq_r <= {dq_r[55:0], 1'b0};
      end
    end
    if (cmd.rate_done) begin
      if (dt_r == '0)
        rate_r <= diff[32] ? 32'sh8000_0000 : (diff == '0 ? 32'sd0 : 32'sh7FFF_FFFF);
      else
        rate_r <= sat32(64'(qs));
    end
    if (cmd.integ) werr_r <= werr_c;
    if (cmd.finish) begin
      res_sh <= (tq_sh_r == '0) ? (stl_r[31] ? -32'sd1 : 32'sd1) : sat32(-tq_sh_r);
      res_el <= (tq_el_r == '0) ? (etl_r[31] ? -32'sd1 : 32'sd1) : sat32(tq_el_r);
      res_wh <= sat32(-acc_q);
      res_rate <= rate_r;
    end
  end

endmodule

### sv/joint_pd_wheel_pi_controller_core.sv
// Joint PD and reaction wheel PI servo controller.
// in_ channel: one item per handshake, action in tuser, other fields in tdata.
// A sample item (tuser 0) updates at most one stored reading and gives no
// result. A tick item (tuser 1) gives one result item of four torques/rate
// on the out_ channel; out_tvalid rises when the tick is worked through and
// the result register is free. The work runs through the 57-step restoring
// divider for the wheel rate and the single shared 33x32 multiplier, used
// once per gain term (twice for the integral term).
// One item is worked on at a time: in_tready is high only when idle, so a
// new item is not accepted until the last one is through.
// The result register holds its item until out_tready; a finished tick
// waits in the sequencer while that register is full, and the next item
// is accepted on the cycle after the result is loaded.
// cfg_ channel: index/data writes, always ready; write only while idle.
// Reset (rst_n low, synchronous) restores the default gains and clears all
// stored readings, the integrator and the previous torques.
module joint_pd_wheel_pi_controller_core
  import jpdpi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: channel[2:0], sample_value[34:3], step_seconds[58:35],
  // shoulder_target_pos[90:59], shoulder_target_vel[122:91],
  // elbow_target_pos[154:123], elbow_target_vel[186:155], zero fill
  input  logic [191:0] in_tdata,
  input  logic         in_tuser, // action
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: shoulder_torque[31:0], elbow_torque[63:32], wheel_torque[95:64],
  // wheel_rate[127:96]
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic busy, out_load, in_fire, out_free;
  cmd_t cmd;
  logic signed [31:0] r_sh, r_el, r_wh, r_rate;
  logic out_valid_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  jpdpi_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_action(in_tuser), .out_free,
    .busy, .out_load, .cmd
  );

  jpdpi_dp u_dp (
    .clk, .rst_n, .cmd, .in_fire,
    .in_channel(in_tdata[2:0]),
    .in_sample_value(in_tdata[34:3]),
    .in_step_seconds(in_tdata[58:35]),
    .in_sh_tp(in_tdata[90:59]),
    .in_sh_tv(in_tdata[122:91]),
    .in_el_tp(in_tdata[154:123]),
    .in_el_tv(in_tdata[186:155]),
    .cfg_fire(cfg_valid && cfg_ready),
    .cfg_index, .cfg_data,
    .res_sh(r_sh), .res_el(r_el), .res_wh(r_wh), .res_rate(r_rate)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) out_tdata <= {r_rate, r_wh, r_el, r_sh};
  end
  assign out_tvalid = out_valid_r;

  // No item taken while an item is being worked on
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("item accepted while busy");
  // A result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free) else $error("result overwritten");
  // A sample item never produces a result on the next cycle
  a_sample_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tuser) |=> !out_load) else $error("sample made result");

endmodule
